### design/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiply block
// Command and register codes, field widths, control structs between the
// sequencer, the MAC unit and the top level.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 40;
    localparam int COORD_W    = 3;
    localparam int DIM_REG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    // one operand read issued to the MAC pipeline
    typedef struct packed {
        logic rd;
        logic first;
        logic fin;
    } t_issue;

    // result element handed to the output register
    typedef struct packed {
        logic               load;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_emit;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_REG_W-1:0] dim_clamp(
        input logic [DIM_REG_W-1:0] v,
        input logic [DIM_REG_W-1:0] vmax
    );
        logic [DIM_REG_W-1:0] r;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > vmax) begin
            r = vmax;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### design/mm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_if: channel interfaces of the matrix multiply block
// Command channel (loads and compute requests) and result channel.
// ----------------------------------------------------------------------------
interface mm_cmd_if
    import mm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  element_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, command, element_index, element_value, input ready);
    modport sink   (input valid, command, element_index, element_value, output ready);
endinterface

interface mm_res_if
    import mm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [COORD_W-1:0]       out_row;
    logic [COORD_W-1:0]       out_col;
    logic signed [SUM_W-1:0]  product_sum;
    logic                     last;

    modport source (output valid, out_row, out_col, product_sum, last, input ready);
    modport sink   (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

### design/mm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_store: operand memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_store
    import mm_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [ELEM_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [ELEM_W-1:0] o_rdata
);

    logic signed [ELEM_W-1:0] r_mem [0:DEPTH-1];
    logic signed [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_mac: shared multiply-accumulate unit
// Registered 16x16 product, then a 40-bit accumulator that restarts on the
// first term of each dot product and flags the cycle its sum is complete.
// ----------------------------------------------------------------------------
module mm_mac
    import mm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_issue                   i_issue,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    output logic signed [SUM_W-1:0]  o_acc,
    output logic                     o_done
);

    // tags aligned with the read data, then with the product
    t_issue r_tag1, r_tag2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag1 <= i_issue;
            r_tag2 <= r_tag1;
            r_done <= r_tag2.rd & r_tag2.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    always_comb begin
        n_acc = r_acc;
        if (r_tag2.rd) begin
            if (r_tag2.first) begin
                n_acc = SUM_W'(r_prod);
            end else begin
                n_acc = r_acc + SUM_W'(r_prod);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

### design/mm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_seq: compute sequencer
// Walks rows, columns and inner terms, issues operand addresses to the
// stores and hands each finished sum to the output register.
// ----------------------------------------------------------------------------
module mm_seq
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int AW      = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIM_REG_W-1:0] i_rows_a,
    input  logic [DIM_REG_W-1:0] i_inner_size,
    input  logic [DIM_REG_W-1:0] i_cols_b,
    input  logic                 i_out_free,
    input  logic                 i_mac_done,
    output logic                 o_idle,
    output t_issue               o_issue,
    output logic [AW-1:0]        o_a_addr,
    output logic [AW-1:0]        o_b_addr,
    output t_emit                o_emit
);

    localparam int DCW = $clog2(MAX_DIM + 1);
    localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [DCW-1:0] r_nr, n_nr, r_nk, n_nk, r_nc, n_nc;
    logic [DW-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [AW-1:0]  r_a_base, n_a_base, r_a_addr, n_a_addr, r_b_addr, n_b_addr;
    logic           last_k, last_i, last_j;
    logic [AW-1:0]  next_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_nr     <= n_nr;
        r_nk     <= n_nk;
        r_nc     <= n_nc;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_a_base <= n_a_base;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
    end

    assign last_k    = (r_k == DW'(r_nk - DCW'(1)));
    assign last_i    = (r_i == DW'(r_nr - DCW'(1)));
    assign last_j    = (r_j == DW'(r_nc - DCW'(1)));
    assign next_base = r_a_base + AW'(r_nk);

    always_comb begin
        n_state  = r_state;
        n_nr     = r_nr;
        n_nk     = r_nk;
        n_nc     = r_nc;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a_base = r_a_base;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        o_issue  = '0;
        o_emit.load = 1'b0;
        o_emit.row  = COORD_W'(r_i);
        o_emit.col  = COORD_W'(r_j);
        o_emit.last = last_i & last_j;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_nr     = DCW'(dim_clamp(i_rows_a, DIM_REG_W'(MAX_DIM)));
                    n_nk     = DCW'(dim_clamp(i_inner_size, DIM_REG_W'(MAX_DIM)));
                    n_nc     = DCW'(dim_clamp(i_cols_b, DIM_REG_W'(MAX_DIM)));
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_a_base = '0;
                    n_a_addr = '0;
                    n_b_addr = '0;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                o_issue.rd    = 1'b1;
                o_issue.first = (r_k == '0);
                o_issue.fin   = last_k;
                if (last_k) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k      = r_k + DW'(1);
                    n_a_addr = r_a_addr + AW'(1);
                    n_b_addr = r_b_addr + AW'(r_nc);
                end
            end
            ST_WAIT: begin
                if (i_mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    if (last_j) begin
                        n_j = '0;
                        if (last_i) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i      = r_i + DW'(1);
                            n_a_base = next_base;
                            n_a_addr = next_base;
                            n_b_addr = '0;
                            n_state  = ST_RUN;
                        end
                    end else begin
                        n_j      = r_j + DW'(1);
                        n_a_addr = r_a_base;
                        n_b_addr = AW'(r_j) + AW'(1);
                        n_state  = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle   = (r_state == ST_IDLE);
    assign o_a_addr = r_a_addr;
    assign o_b_addr = r_b_addr;

endmodule

### design/matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_top: dense fixed-point matrix product C = A x B
// Q8.8 operands loaded by index, Q24.16 results streamed in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one beat per command. A write-A or write-B beat stores a
//   Q8.8 element at a row-major index; indexes beyond the store are
//   dropped. A compute beat walks the result and sends one beat per
//   element on o_res, row by row, with last set on the final element.
//   Dimensions come from the three configuration registers (zero reads as
//   one, values above MAX_DIM as MAX_DIM); write them only while idle.
// Timing:
//   Loads are taken every cycle while no compute runs. A compute holds
//   i_cmd.ready low while the single shared MAC unit runs: each result
//   element takes one operand pair per cycle, then read, multiply and
//   accumulate and the hand-off before the next element starts.
// Reset and stalls:
//   Reset empties the output register, returns the sequencer to idle and
//   sets all dimensions to 8; store contents stay undefined until written.
//   When o_res stalls, hold the finished beat and freeze the sequencer
//   before the next hand-off; new commands are taken again once the final
//   element sits in the output register.
// ----------------------------------------------------------------------------
module matrix_multiply_top
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mm_cmd_if.sink                i_cmd,
    mm_res_if.source              o_res
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [DIM_REG_W-1:0] r_rows_a, r_inner_size, r_cols_b;

    // output register
    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_out_row, r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    logic                     cmd_accept;
    logic                     idx_ok;
    logic                     we_a, we_b;
    logic                     seq_idle;
    logic                     out_free;
    logic                     mac_done;
    t_issue                   issue;
    t_emit                    emit;
    logic [AW-1:0]            a_addr, b_addr;
    logic signed [ELEM_W-1:0] a_data, b_data;
    logic signed [SUM_W-1:0]  acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= DIM_RESET;
            r_inner_size <= DIM_RESET;
            r_cols_b     <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:     r_rows_a     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_B:     r_cols_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // take commands only while the sequencer rests
    assign i_cmd.ready = seq_idle;
    assign cmd_accept  = i_cmd.valid & seq_idle;

    // drop loads outside the store
    assign idx_ok = ({1'b0, i_cmd.element_index} < (IDX_W + 1)'(DEPTH));
    assign we_a   = cmd_accept & idx_ok & (i_cmd.command == CMD_WRITE_A);
    assign we_b   = cmd_accept & idx_ok & (i_cmd.command == CMD_WRITE_B);

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_cmd.element_index[AW-1:0]),
        .i_wdata (i_cmd.element_value),
        .i_raddr (a_addr),
        .o_rdata (a_data)
    );

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_cmd.element_index[AW-1:0]),
        .i_wdata (i_cmd.element_value),
        .i_raddr (b_addr),
        .o_rdata (b_data)
    );

    // output register is free when empty or drained this cycle
    assign out_free = ~r_out_valid | o_res.ready;

    mm_seq #(.MAX_DIM(MAX_DIM), .AW(AW)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (cmd_accept & (i_cmd.command == CMD_COMPUTE)),
        .i_rows_a     (r_rows_a),
        .i_inner_size (r_inner_size),
        .i_cols_b     (r_cols_b),
        .i_out_free   (out_free),
        .i_mac_done   (mac_done),
        .o_idle       (seq_idle),
        .o_issue      (issue),
        .o_a_addr     (a_addr),
        .o_b_addr     (b_addr),
        .o_emit       (emit)
    );

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_a     (a_data),
        .i_b     (b_data),
        .o_acc   (acc),
        .o_done  (mac_done)
    );

    // load a finished element, clear valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_row  <= emit.row;
            r_out_col  <= emit.col;
            r_out_sum  <= acc;
            r_out_last <= emit.last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_row     = r_out_row;
    assign o_res.out_col     = r_out_col;
    assign o_res.product_sum = r_out_sum;
    assign o_res.last        = r_out_last;

endmodule

### design/mm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_checker: port-level checks for the matrix multiply block
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module mm_checker
    import mm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic [CMD_W-1:0]        i_in_command,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [COORD_W-1:0]      i_out_row,
    input logic [COORD_W-1:0]      i_out_col,
    input logic signed [SUM_W-1:0] i_out_sum,
    input logic                    i_out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row)
            && $stable(i_out_col) && $stable(i_out_sum) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // a compute request makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_COMPUTE) |=> !i_in_ready)
        else $error("block still ready after a compute request");

    // loads and unused commands never produce a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command != CMD_COMPUTE) && !i_out_valid
            |=> !i_out_valid)
        else $error("result appeared after a non-compute command");

    // the block returns to ready only with the final element on the output
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(i_in_ready) |-> i_out_valid && i_out_last)
        else $error("ready returned without the final element pending");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_in_command (i_cmd.command),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_row    (o_res.out_row),
    .i_out_col    (o_res.out_col),
    .i_out_sum    (o_res.product_sum),
    .i_out_last   (o_res.last)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking test of the fixed-point matrix multiply block
// Loads Q8.8 elements of A and B, sets the three dimension registers to
// small and corner sizes, and issues compute commands. A scoreboard predicts
// every Q24.16 result beat of each product and checks it in order, while the
// command side sends in random bursts and the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import mm_pkg::*;

    localparam int STORE_DEPTH    = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 110;

    // command code the block does not use; it must be ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one expected element of the product
    typedef struct packed {
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } product_elem_t;

    // result-side stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_SPARSE,
        RDY_LONG_HOLD
    } ready_mode_t;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mm_cmd_if cmd_if ();
    mm_res_if res_if ();

    matrix_multiply_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // ------------------------------------------------------------------------
    // Predictor state: shadow of both operand stores and the dimension
    // registers, plus which store entries have been written since reset.
    // ------------------------------------------------------------------------
    logic signed [ELEM_W-1:0] a_elems [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_elems [STORE_DEPTH];
    bit                       a_loaded [STORE_DEPTH];
    bit                       b_loaded [STORE_DEPTH];
    logic [DIM_REG_W-1:0]     rows_a_reg;
    logic [DIM_REG_W-1:0]     inner_reg;
    logic [DIM_REG_W-1:0]     cols_b_reg;

    product_elem_t product_q [$];
    int            fail_count;
    int            burst_left;
    int            random_beats;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Zero reads as one and anything beyond the largest size as that size.
    function automatic int effective_dim(input logic [DIM_REG_W-1:0] reg_val);
        int d;
        d = int'(reg_val);
        if (d == 0) begin
            d = 1;
        end else if (d > MAX_DIM_DEF) begin
            d = MAX_DIM_DEF;
        end
        return d;
    endfunction

    // Push every element of C = A x B, row by row, onto the expected queue.
    function automatic void predict_product();
        int            nr;
        int            nk;
        int            nc;
        longint        acc;
        product_elem_t elem;
        nr = effective_dim(rows_a_reg);
        nk = effective_dim(inner_reg);
        nc = effective_dim(cols_b_reg);
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                acc = 0;
                for (int k = 0; k < nk; k++) begin
                    acc += longint'(a_elems[(r * nk + k) % STORE_DEPTH])
                         * longint'(b_elems[(k * nc + c) % STORE_DEPTH]);
                end
                elem.row  = COORD_W'(r);
                elem.col  = COORD_W'(c);
                elem.sum  = SUM_W'(acc);
                elem.last = (r == nr - 1) && (c == nc - 1);
                product_q.push_back(elem);
            end
        end
    endfunction

    // Apply one accepted command beat to the shadow state.
    function automatic void apply_command(
        input logic [CMD_W-1:0]       cmd,
        input logic [IDX_W-1:0]       idx,
        input logic signed [ELEM_W-1:0] val
    );
        case (cmd)
            CMD_WRITE_A: begin
                a_elems[idx]  = val;
                a_loaded[idx] = 1'b1;
            end
            CMD_WRITE_B: begin
                b_elems[idx]  = val;
                b_loaded[idx] = 1'b1;
            end
            CMD_COMPUTE: begin
                predict_product();
            end
            default: begin
            end
        endcase
    endfunction

    // Full-range values half of the time, the corners of Q8.8 the other half.
    function automatic logic signed [ELEM_W-1:0] pick_value();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = 16'sh0000;
            3:       v = 16'shFFFF;
            default: v = ELEM_W'($urandom);
        endcase
        return v;
    endfunction

    // Small sizes most of the time, the corners now and then.
    function automatic logic [DIM_REG_W-1:0] pick_dim();
        logic [DIM_REG_W-1:0] d;
        case ($urandom_range(0, 15))
            0:       d = '0;
            1:       d = DIM_REG_W'($urandom_range(MAX_DIM_DEF + 1, 15));
            2:       d = DIM_REG_W'(MAX_DIM_DEF);
            default: d = DIM_REG_W'($urandom_range(1, 4));
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Command side: one beat per call, sent in bursts with random gaps
    // ------------------------------------------------------------------------
    task automatic send_command(
        input logic [CMD_W-1:0]         cmd,
        input logic [IDX_W-1:0]         idx,
        input logic signed [ELEM_W-1:0] val
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            // about one burst in four follows the previous one back to back
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.element_index <= idx;
        cmd_if.element_value <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        apply_command(cmd, idx, val);
        if (cmd != CMD_UNUSED) begin
            random_beats++;
        end
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (product_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS_A:     rows_a_reg = data;
            CFG_INNER_SIZE: inner_reg  = data;
            CFG_COLS_B:     cols_b_reg = data;
            default: begin
            end
        endcase
    endtask

    // Only touch the registers once the block has gone quiet.
    task automatic set_dims(
        input logic [DIM_REG_W-1:0] rows,
        input logic [DIM_REG_W-1:0] inner,
        input logic [DIM_REG_W-1:0] cols
    );
        wait_idle();
        write_reg(CFG_ROWS_A, rows);
        write_reg(CFG_INNER_SIZE, inner);
        write_reg(CFG_COLS_B, cols);
    endtask

    // Load every entry the next compute will read that is still unwritten,
    // so no compute ever reads an undefined store entry.
    task automatic load_missing(input bit most_negative);
        int na;
        int nb;
        na = effective_dim(rows_a_reg) * effective_dim(inner_reg);
        nb = effective_dim(inner_reg) * effective_dim(cols_b_reg);
        for (int i = 0; i < na; i++) begin
            if (!a_loaded[i]) begin
                send_command(CMD_WRITE_A, IDX_W'(i),
                             most_negative ? 16'sh8000 : pick_value());
            end
        end
        for (int i = 0; i < nb; i++) begin
            if (!b_loaded[i]) begin
                send_command(CMD_WRITE_B, IDX_W'(i),
                             most_negative ? 16'sh8000 : pick_value());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Reset dimensions (8 x 8 x 8) with every operand at the most negative
    // Q8.8 value: each sum reaches its largest magnitude.
    task automatic test_reset_dims_full_scale();
        load_missing(1'b1);
        send_command(CMD_COMPUTE, '0, '0);
    endtask

    // Register corners: above the maximum clamps, zero reads as one, and
    // the degenerate vector shapes.
    task automatic test_dim_limits();
        set_dims(4'd15, 4'd15, 4'd15);
        send_command(CMD_COMPUTE, '0, '0);
        set_dims(4'd0, 4'd0, 4'd0);
        send_command(CMD_COMPUTE, '0, '0);
        set_dims(4'd1, 4'd8, 4'd1);
        send_command(CMD_COMPUTE, '0, '0);
        set_dims(4'd8, 4'd1, 4'd8);
        send_command(CMD_COMPUTE, '0, '0);
    endtask

    // Single-element products around the corners of the element range, writes to
    // the top store index, and the unused command in the middle of a sequence.
    task automatic test_element_corners();
        set_dims(4'd1, 4'd1, 4'd1);
        send_command(CMD_WRITE_A, 6'd0, 16'sh7FFF);
        send_command(CMD_WRITE_B, 6'd0, 16'sh8000);
        send_command(CMD_COMPUTE, '0, '0);
        send_command(CMD_WRITE_A, 6'd63, 16'sh5555);
        send_command(CMD_WRITE_B, 6'd63, 16'shAAAA);
        send_command(CMD_UNUSED, 6'd42, 16'sh1234);
        send_command(CMD_COMPUTE, '0, '0);
        send_command(CMD_WRITE_A, 6'd0, 16'sh0000);
        send_command(CMD_COMPUTE, '0, '0);
        send_command(CMD_WRITE_A, 6'd0, 16'shFFFF);
        send_command(CMD_WRITE_B, 6'd0, 16'sh7FFF);
        send_command(CMD_COMPUTE, '0, '0);
    endtask

    // Random shapes; for each, a few load-then-compute sequences with some
    // stray loads and unused commands mixed in.
    task automatic test_random_products();
        int na;
        int nb;
        int n_loads;
        random_beats = 0;
        while (random_beats < RANDOM_BEATS) begin
            set_dims(pick_dim(), pick_dim(), pick_dim());
            na = effective_dim(rows_a_reg) * effective_dim(inner_reg);
            nb = effective_dim(inner_reg) * effective_dim(cols_b_reg);
            repeat ($urandom_range(1, 3)) begin
                n_loads = $urandom_range(0, 8);
                for (int i = 0; i < n_loads; i++) begin
                    case ($urandom_range(0, 11))
                        0: send_command(CMD_UNUSED, IDX_W'($urandom), pick_value());
                        1: send_command(CMD_WRITE_A, IDX_W'($urandom), pick_value());
                        2: send_command(CMD_WRITE_B, IDX_W'($urandom), pick_value());
                        3, 4, 5, 6: send_command(CMD_WRITE_A,
                                                 IDX_W'($urandom_range(0, na - 1)),
                                                 pick_value());
                        default: send_command(CMD_WRITE_B,
                                              IDX_W'($urandom_range(0, nb - 1)),
                                              pick_value());
                    endcase
                end
                load_missing(1'b0);
                send_command(CMD_COMPUTE, IDX_W'($urandom), ELEM_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_WRITE_A;
        cmd_if.element_index = '0;
        cmd_if.element_value = '0;
        rows_a_reg           = DIM_RESET;
        inner_reg            = DIM_RESET;
        cols_b_reg           = DIM_RESET;
        fail_count           = 0;
        burst_left           = 0;
        random_beats         = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            a_elems[i]  = '0;
            b_elems[i]  = '0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_dims_full_scale();
        test_dim_limits();
        test_element_corners();
        test_random_products();

        // drain every outstanding beat, then give the block time to show
        // anything extra
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready follows its own stall pattern, switching between
    // always ready, sparse random stalls and long holds.
    // ------------------------------------------------------------------------
    ready_mode_t ready_mode;
    int          mode_left;
    int          hold_left;

    initial begin
        res_if.ready = 1'b0;
        ready_mode   = RDY_ALWAYS;
        mode_left    = 0;
        hold_left    = 0;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (ready_mode)
            RDY_ALWAYS: begin
                res_if.ready <= 1'b1;
            end
            RDY_SPARSE: begin
                res_if.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    res_if.ready <= 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    hold_left = $urandom_range(1, 20);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Scoreboard: compare each accepted result beat with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        product_elem_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (product_q.size() == 0) begin
                $error("unexpected result beat: row %0d col %0d sum %0d",
                       res_if.out_row, res_if.out_col, res_if.product_sum);
                fail_count++;
            end else begin
                want = product_q.pop_front();
                if (res_if.out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, res_if.out_row);
                    fail_count++;
                end
                if (res_if.out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, res_if.out_col);
                    fail_count++;
                end
                if (res_if.product_sum !== want.sum) begin
                    $error("product_sum: expected %0d, got %0d",
                           want.sum, res_if.product_sum);
                    fail_count++;
                end
                if (res_if.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_if.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves a beat for too long.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
